[src/tafb_pkg.sv]
`timescale 1ns / 1ps

package tafb_pkg;

    // field widths
    localparam int PIX_W     = 16;
    localparam int IDX_W     = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;

    // divider: 13-bit divisor, 17-bit Q1.16 quotient (1.0 = 65536)
    localparam int DEN_W = 13;
    localparam int Q_W   = 17;
    localparam int DVD_W = DEN_W + Q_W;
    localparam int MUL_W = PIX_W + Q_W;

    localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);

    localparam int DEFAULT_MAX_DIM = 4096;

    // stage counts: prep, one stage per quotient bit, four mix stages
    localparam int MIX_STG = 4;
    localparam int N_STG   = 1 + Q_W + MIX_STG;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = CFG_IDX_W'(5);

    // ramp end-point pixels
    typedef struct packed {
        logic [PIX_W-1:0] p0h;
        logic [PIX_W-1:0] p1h;
        logic [PIX_W-1:0] p0v;
        logic [PIX_W-1:0] p1v;
    } pix_set_t;

    // one division num/den, num <= den, den >= 1
    typedef struct packed {
        logic [DEN_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_op_t;

endpackage

[src/two_axis_feather_blend.sv]
`timescale 1ns / 1ps

// Two-axis feathered blend of two aligned 16-bit images.
// Input channel (in_valid/in_ready): one pixel of each image with its row
// and column. Output channel (out_valid/out_ready): the blended pixel.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): frame size and
// ramp source selects; always ready, write only while the pipeline is empty.
// Pipeline from input transaction to output valid: one prep stage,
// a 17-stage divider pipeline (one quotient bit per stage, three dividers in
// parallel for the horizontal, vertical and diagonal weights) and four
// multiply/round stages.
// Throughput: one pixel per clock, sustained while out_ready is high.
// Reset clears all valid bits and sets 2x2 frame, all sources from the
// first image. When out_ready is low, each stage holds only while the stage
// after it is full, so empty slots keep filling and input keeps being taken
// until the whole pipeline is full; nothing is lost or repeated.
module two_axis_feather_blend #(
    parameter int MAX_DIM = tafb_pkg::DEFAULT_MAX_DIM
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tafb_pkg::PIX_W-1:0]     first_pixel,
    input  logic [tafb_pkg::PIX_W-1:0]     second_pixel,
    input  logic [tafb_pkg::IDX_W-1:0]     row_index,
    input  logic [tafb_pkg::IDX_W-1:0]     col_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tafb_pkg::PIX_W-1:0]     blended_pixel,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tafb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tafb_pkg::CFG_W-1:0]     cfg_data
);

    localparam int N_STG = tafb_pkg::N_STG;
    localparam int Q_W   = tafb_pkg::Q_W;

    logic [tafb_pkg::CFG_W-1:0] rows_reg, cols_reg;
    logic left_reg, right_reg, top_reg, bottom_reg;

    logic [N_STG-1:0] vld_reg;
    logic [N_STG:0]   en;

    tafb_pkg::pix_set_t pix0;
    tafb_pkg::div_op_t  op_h, op_v, op_d;
    logic [Q_W-1:0]     wh, wv, wd;
    tafb_pkg::pix_set_t pd_reg [Q_W];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= tafb_pkg::CFG_W'(2);
            cols_reg   <= tafb_pkg::CFG_W'(2);
            left_reg   <= 1'b0;
            right_reg  <= 1'b0;
            top_reg    <= 1'b0;
            bottom_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tafb_pkg::REG_ROWS:   rows_reg   <= cfg_data;
                tafb_pkg::REG_COLS:   cols_reg   <= cfg_data;
                tafb_pkg::REG_LEFT:   left_reg   <= cfg_data[0];
                tafb_pkg::REG_RIGHT:  right_reg  <= cfg_data[0];
                tafb_pkg::REG_TOP:    top_reg    <= cfg_data[0];
                tafb_pkg::REG_BOTTOM: bottom_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // per-stage enables: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[N_STG] = out_ready;
        for (int k = N_STG - 1; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < N_STG; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[N_STG-1];

    tafb_prep #(
        .MAX_DIM (MAX_DIM)
    ) u_prep (
        .clk                (clk),
        .en                 (en[0]),
        .first_pixel        (first_pixel),
        .second_pixel       (second_pixel),
        .row_index          (row_index),
        .col_index          (col_index),
        .image_rows         (rows_reg),
        .image_cols         (cols_reg),
        .left_from_second   (left_reg),
        .right_from_second  (right_reg),
        .top_from_second    (top_reg),
        .bottom_from_second (bottom_reg),
        .pix                (pix0),
        .op_h               (op_h),
        .op_v               (op_v),
        .op_d               (op_d)
    );

    tafb_div u_div_h (.clk(clk), .en(en[Q_W:1]), .op(op_h), .quo(wh));
    tafb_div u_div_v (.clk(clk), .en(en[Q_W:1]), .op(op_v), .quo(wv));
    tafb_div u_div_d (.clk(clk), .en(en[Q_W:1]), .op(op_d), .quo(wd));

    // pixels ride alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (en[1])
            pd_reg[0] <= pix0;
        for (int k = 1; k < Q_W; k++)
            if (en[k+1])
                pd_reg[k] <= pd_reg[k-1];
    end

    tafb_mix u_mix (
        .clk     (clk),
        .en      (en[N_STG-1:Q_W+1]),
        .pix     (pd_reg[Q_W-1]),
        .wh      (wh),
        .wv      (wv),
        .wd      (wd),
        .blended (blended_pixel)
    );

endmodule

[src/tafb_prep.sv]
`timescale 1ns / 1ps

module tafb_prep #(
    parameter int MAX_DIM = tafb_pkg::DEFAULT_MAX_DIM
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [tafb_pkg::PIX_W-1:0] first_pixel,
    input  logic [tafb_pkg::PIX_W-1:0] second_pixel,
    input  logic [tafb_pkg::IDX_W-1:0] row_index,
    input  logic [tafb_pkg::IDX_W-1:0] col_index,
    input  logic [tafb_pkg::CFG_W-1:0] image_rows,
    input  logic [tafb_pkg::CFG_W-1:0] image_cols,
    input  logic                       left_from_second,
    input  logic                       right_from_second,
    input  logic                       top_from_second,
    input  logic                       bottom_from_second,
    output tafb_pkg::pix_set_t         pix,
    output tafb_pkg::div_op_t          op_h,
    output tafb_pkg::div_op_t          op_v,
    output tafb_pkg::div_op_t          op_d
);

    localparam int DIM_TOP = (1 << tafb_pkg::CFG_W) - 1;
    localparam int DIM_LIM = (MAX_DIM > DIM_TOP) ? DIM_TOP : MAX_DIM;
    localparam logic [tafb_pkg::CFG_W-1:0] LIM = tafb_pkg::CFG_W'(DIM_LIM);
    localparam logic [tafb_pkg::CFG_W-1:0] TWO = tafb_pkg::CFG_W'(2);

    logic [tafb_pkg::CFG_W-1:0] rows_c, cols_c, rows_m1, cols_m1;
    logic [tafb_pkg::CFG_W-1:0] ic, jc, dx, dnum;
    logic                       left_half, top_half;

    tafb_pkg::pix_set_t pix_next, pix_reg;
    tafb_pkg::div_op_t  oph_next, opv_next, opd_next;
    tafb_pkg::div_op_t  oph_reg, opv_reg, opd_reg;

    // clamp dimensions and indices, form the three divisions
    always_comb
    begin
        rows_c = image_rows;
        if (image_rows < TWO)
            rows_c = TWO;
        else if (image_rows > LIM)
            rows_c = LIM;
        cols_c = image_cols;
        if (image_cols < TWO)
            cols_c = TWO;
        else if (image_cols > LIM)
            cols_c = LIM;
        rows_m1 = rows_c - 1'b1;
        cols_m1 = cols_c - 1'b1;

        ic = {1'b0, row_index};
        if (ic > rows_m1)
            ic = rows_m1;
        jc = {1'b0, col_index};
        if (jc > cols_m1)
            jc = cols_m1;

        left_half = (jc <= (cols_c >> 1));
        top_half  = (ic <= (rows_c >> 1));
        dx   = left_half ? jc : (cols_c - jc);
        dnum = top_half  ? ic : (rows_c - ic);

        oph_next.num = jc;
        oph_next.den = cols_m1;
        opv_next.num = ic;
        opv_next.den = rows_m1;
        // origin: weight is exactly one
        if (ic == '0 && jc == '0)
        begin
            opd_next.num = tafb_pkg::DEN_W'(1);
            opd_next.den = tafb_pkg::DEN_W'(1);
        end
        else
        begin
            opd_next.num = dnum;
            opd_next.den = dx + dnum;
        end

        pix_next.p0h = left_from_second   ? second_pixel : first_pixel;
        pix_next.p1h = right_from_second  ? second_pixel : first_pixel;
        pix_next.p0v = top_from_second    ? second_pixel : first_pixel;
        pix_next.p1v = bottom_from_second ? second_pixel : first_pixel;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg <= pix_next;
            oph_reg <= oph_next;
            opv_reg <= opv_next;
            opd_reg <= opd_next;
        end
    end

    assign pix  = pix_reg;
    assign op_h = oph_reg;
    assign op_v = opv_reg;
    assign op_d = opd_reg;

endmodule

[src/tafb_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage.
// q = floor((num * 65536 + den / 2) / den), never above 65536.
module tafb_div (
    input  logic                      clk,
    input  logic [tafb_pkg::Q_W-1:0]  en,
    input  tafb_pkg::div_op_t         op,
    output logic [tafb_pkg::Q_W-1:0]  quo
);

    localparam int DEN_W = tafb_pkg::DEN_W;
    localparam int Q_W   = tafb_pkg::Q_W;
    localparam int DVD_W = tafb_pkg::DVD_W;

    logic [DVD_W-1:0] dividend;

    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   lo_reg  [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];

    // rounded dividend; its top part is already below den
    assign dividend = {1'b0, op.num, {(Q_W-1){1'b0}}} + DVD_W'(op.den >> 1);

    genvar k;
    generate
        for (k = 0; k < Q_W; k++)
        begin : g_step
            logic [DEN_W-1:0] src_rem, src_den, rem_next;
            logic [Q_W-1:0]   src_lo, src_q;
            logic [DEN_W:0]   trial, diff;
            logic             ge;

            if (k == 0)
            begin : g_first
                assign src_rem = dividend[DVD_W-1:Q_W];
                assign src_lo  = dividend[Q_W-1:0];
                assign src_den = op.den;
                assign src_q   = '0;
            end
            else
            begin : g_next
                assign src_rem = rem_reg[k-1];
                assign src_lo  = lo_reg[k-1];
                assign src_den = den_reg[k-1];
                assign src_q   = q_reg[k-1];
            end

            // shift in one dividend bit, subtract when it fits
            always_comb
            begin
                trial    = {src_rem, src_lo[Q_W-1]};
                diff     = trial - {1'b0, src_den};
                ge       = (trial >= {1'b0, src_den});
                rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k] <= rem_next;
                    lo_reg[k]  <= {src_lo[Q_W-2:0], 1'b0};
                    den_reg[k] <= src_den;
                    q_reg[k]   <= {src_q[Q_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign quo = q_reg[Q_W-1];

endmodule

[src/tafb_mix.sv]
`timescale 1ns / 1ps

// Ramp blends (rounded, saturated) then diagonal mix (truncated).
module tafb_mix (
    input  logic                              clk,
    input  logic [tafb_pkg::MIX_STG-1:0]      en,
    input  tafb_pkg::pix_set_t                pix,
    input  logic [tafb_pkg::Q_W-1:0]          wh,
    input  logic [tafb_pkg::Q_W-1:0]          wv,
    input  logic [tafb_pkg::Q_W-1:0]          wd,
    output logic [tafb_pkg::PIX_W-1:0]        blended
);

    localparam int PIX_W = tafb_pkg::PIX_W;
    localparam int Q_W   = tafb_pkg::Q_W;
    localparam int MUL_W = tafb_pkg::MUL_W;
    localparam int SUM_W = MUL_W + 1;
    localparam logic [SUM_W-1:0] HALF = SUM_W'(32768);
    localparam logic [SUM_W-Q_W:0] PMAX = (SUM_W-Q_W+1)'(65535);

    logic [MUL_W-1:0] mh0_reg, mh1_reg, mv0_reg, mv1_reg;
    logic [Q_W-1:0]   wd1_reg, wd2_reg;
    logic [PIX_W-1:0] h_reg, v_reg;
    logic [MUL_W-1:0] fh_reg, fv_reg;
    logic [PIX_W-1:0] res_reg;

    logic [SUM_W-1:0]   sh, sv, sf;
    logic [SUM_W-Q_W:0] th, tv;
    logic [PIX_W-1:0]   h_next, v_next;

    always_comb
    begin
        sh = SUM_W'(mh0_reg) + SUM_W'(mh1_reg) + HALF;
        sv = SUM_W'(mv0_reg) + SUM_W'(mv1_reg) + HALF;
        th = sh[SUM_W-1:Q_W-1];
        tv = sv[SUM_W-1:Q_W-1];
        h_next = (th > PMAX) ? '1 : th[PIX_W-1:0];
        v_next = (tv > PMAX) ? '1 : tv[PIX_W-1:0];
        sf = SUM_W'(fh_reg) + SUM_W'(fv_reg);
    end

    always_ff @(posedge clk)
    begin
        // ramp products
        if (en[0])
        begin
            mh0_reg <= MUL_W'(pix.p0h) * MUL_W'(tafb_pkg::ONE_Q16 - wh);
            mh1_reg <= MUL_W'(pix.p1h) * MUL_W'(wh);
            mv0_reg <= MUL_W'(pix.p0v) * MUL_W'(tafb_pkg::ONE_Q16 - wv);
            mv1_reg <= MUL_W'(pix.p1v) * MUL_W'(wv);
            wd1_reg <= wd;
        end
        // ramp round and saturate
        if (en[1])
        begin
            h_reg   <= h_next;
            v_reg   <= v_next;
            wd2_reg <= wd1_reg;
        end
        // diagonal products
        if (en[2])
        begin
            fh_reg <= MUL_W'(h_reg) * MUL_W'(wd2_reg);
            fv_reg <= MUL_W'(v_reg) * MUL_W'(tafb_pkg::ONE_Q16 - wd2_reg);
        end
        // truncate
        if (en[3])
            res_reg <= sf[Q_W+PIX_W-2:Q_W-1];
    end

    assign blended = res_reg;

endmodule
